FILE: rtl/ddpi_pkg.sv
// ddpi_pkg: shared constants, types and tables for the pose integrator.
// Used by ddpi_ctrl, ddpi_dp and diff_drive_pose_integrator.
package ddpi_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int IterW             = $clog2(ATAN_ENTRIES + 1);

    localparam logic signed [15:0] PI_H     = 16'sd25736;
    localparam logic signed [17:0] TWO_PI_H = 18'sd51472;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] CORDIC_START = 36'sd652032874;

    localparam logic [2:0] REG_TIME_STEP = 3'd0;
    localparam logic [2:0] REG_FRONT_X   = 3'd1;
    localparam logic [2:0] REG_FRONT_Y   = 3'd2;
    localparam logic [2:0] REG_SIDE_X    = 3'd3;
    localparam logic [2:0] REG_SIDE_Y    = 3'd4;

    // multiplier operand selects
    typedef enum logic [3:0] {
        MUL_DIST    = 4'd0,   // lin * dt
        MUL_DCOS    = 4'd1,   // dist[23:0] * cos
        MUL_DSIN    = 4'd2,   // dist[23:0] * sin
        MUL_ROT     = 4'd3,   // rot * dt
        MUL_CFX     = 4'd4,
        MUL_SFY     = 4'd5,
        MUL_SFX     = 4'd6,
        MUL_CFY     = 4'd7,
        MUL_CSX     = 4'd8,
        MUL_SSY     = 4'd9,
        MUL_SSX     = 4'd10,
        MUL_CSY     = 4'd11,
        MUL_DCOS_HI = 4'd12,  // dist[40:24] * cos
        MUL_DSIN_HI = 4'd13   // dist[40:24] * sin
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;     // capture input transaction
        logic     cordic_init; // start CORDIC on current heading
        logic     cordic_step;
        logic     cordic_done; // round and latch cos/sin
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     heading_upd;
        logic     load_corner;
        logic [1:0] corner;
    } dp_cmd_t;

    typedef struct packed {
        logic last_iter;
    } dp_stat_t;

    function automatic logic signed [35:0] atan_q30(input logic [IterW-1:0] i);
        case (i)
            5'd0:  atan_q30 = 36'sd843314857;
            5'd1:  atan_q30 = 36'sd497837829;
            5'd2:  atan_q30 = 36'sd263043837;
            5'd3:  atan_q30 = 36'sd133525159;
            5'd4:  atan_q30 = 36'sd67021687;
            5'd5:  atan_q30 = 36'sd33543516;
            5'd6:  atan_q30 = 36'sd16775851;
            5'd7:  atan_q30 = 36'sd8388437;
            5'd8:  atan_q30 = 36'sd4194283;
            5'd9:  atan_q30 = 36'sd2097149;
            5'd10: atan_q30 = 36'sd1048576;
            5'd11: atan_q30 = 36'sd524288;
            5'd12: atan_q30 = 36'sd262144;
            5'd13: atan_q30 = 36'sd131072;
            5'd14: atan_q30 = 36'sd65536;
            5'd15: atan_q30 = 36'sd32768;
            5'd16: atan_q30 = 36'sd16384;
            5'd17: atan_q30 = 36'sd8192;
            5'd18: atan_q30 = 36'sd4096;
            5'd19: atan_q30 = 36'sd2048;
            5'd20: atan_q30 = 36'sd1024;
            5'd21: atan_q30 = 36'sd512;
            5'd22: atan_q30 = 36'sd256;
            5'd23: atan_q30 = 36'sd128;
            default: atan_q30 = 36'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

FILE: rtl/ddpi_dp.sv
// ddpi_dp: datapath - CORDIC, shared multiplier, pose state and corner outputs.
// Depends on ddpi_pkg; steered by ddpi_ctrl.
module ddpi_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ddpi_pkg::dp_cmd_t      cmd,
    output ddpi_pkg::dp_stat_t     stat,
    input  logic signed [23:0]     lin_speed,
    input  logic signed [23:0]     rot_speed,
    input  logic [15:0]            time_step,
    input  logic signed [31:0]     front_x,
    input  logic signed [31:0]     front_y,
    input  logic signed [31:0]     side_x,
    input  logic signed [31:0]     side_y,
    output logic signed [31:0]     corner_x,
    output logic signed [31:0]     corner_y,
    output logic signed [31:0]     pose_x,
    output logic signed [31:0]     pose_y,
    output logic signed [15:0]     pose_heading
);

    logic signed [23:0] lin_reg, rot_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] heading_reg;
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic [ddpi_pkg::IterW-1:0] iter_reg;
    logic signed [24:0] cos_reg, sin_reg;
    logic signed [40:0] dist_reg;
    logic signed [65:0] prod_reg;
    logic signed [36:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] corner_x_reg, corner_y_reg;

    // CORDIC step
    logic signed [35:0] z0, sh_x, sh_y;
    logic signed [35:0] rx, ry;
    always_comb begin
        z0   = 36'(heading_reg) <<< 17;
        sh_x = cx_reg >>> iter_reg;
        sh_y = cy_reg >>> iter_reg;
        rx   = neg_reg ? -cx_reg : cx_reg;
        ry   = neg_reg ? -cy_reg : cy_reg;
    end
    assign stat.last_iter = (iter_reg == ddpi_pkg::IterW'(ddpi_pkg::CORDIC_ITERATIONS - 1));

    // multiplier operands, 33x33 signed; dist is split into two halves
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.mul_sel)
            ddpi_pkg::MUL_DIST: begin ma = 33'(lin_reg); mb = 33'($signed({1'b0, time_step})); end
            ddpi_pkg::MUL_DCOS: begin
                ma = 33'($signed({1'b0, dist_reg[23:0]})); mb = 33'(cos_reg);
            end
            ddpi_pkg::MUL_DSIN: begin
                ma = 33'($signed({1'b0, dist_reg[23:0]})); mb = 33'(sin_reg);
            end
            ddpi_pkg::MUL_DCOS_HI: begin
                ma = 33'($signed(dist_reg[40:24])); mb = 33'(cos_reg);
            end
            ddpi_pkg::MUL_DSIN_HI: begin
                ma = 33'($signed(dist_reg[40:24])); mb = 33'(sin_reg);
            end
            ddpi_pkg::MUL_ROT:  begin ma = 33'(rot_reg); mb = 33'($signed({1'b0, time_step})); end
            ddpi_pkg::MUL_CFX:  begin ma = 33'(cos_reg); mb = 33'(front_x); end
            ddpi_pkg::MUL_SFY:  begin ma = 33'(sin_reg); mb = 33'(front_y); end
            ddpi_pkg::MUL_SFX:  begin ma = 33'(sin_reg); mb = 33'(front_x); end
            ddpi_pkg::MUL_CFY:  begin ma = 33'(cos_reg); mb = 33'(front_y); end
            ddpi_pkg::MUL_CSX:  begin ma = 33'(cos_reg); mb = 33'(side_x); end
            ddpi_pkg::MUL_SSY:  begin ma = 33'(sin_reg); mb = 33'(side_y); end
            ddpi_pkg::MUL_SSX:  begin ma = 33'(sin_reg); mb = 33'(side_x); end
            ddpi_pkg::MUL_CSY:  begin ma = 33'(cos_reg); mb = 33'(side_y); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // prod_reg holds the result of the previous mul_sel; a delayed select
    // routes it into the right accumulator.
    logic     pend_reg;
    ddpi_pkg::mul_sel_t psel_reg;

    logic signed [65:0] rnd38, rnd22v;
    logic signed [39:0] inc_full, h_sum;
    logic signed [15:0] inc_sat;
    always_comb begin
        // low half in acc_reg, high half in prod_reg
        rnd38    = (acc_reg + (prod_reg <<< 24) + (66'sd1 <<< 37)) >>> 38;
        inc_full = 40'((prod_reg + 66'sd262144) >>> 19);
        if (inc_full > 40'(ddpi_pkg::PI_H))       inc_sat = ddpi_pkg::PI_H;
        else if (inc_full < -40'(ddpi_pkg::PI_H)) inc_sat = -ddpi_pkg::PI_H;
        else                                       inc_sat = inc_full[15:0];
        h_sum = 40'(heading_reg) + 40'(inc_sat);
        rnd22v = (acc_reg + prod_reg + (66'sd1 <<< 21)) >>> 22;
    end

    logic signed [39:0] ex_x, ex_y;
    always_comb begin
        case (cmd.corner)
            2'd0: begin ex_x = 40'(pos_x_reg) + 40'(v1x_reg) + 40'(v2x_reg);
                        ex_y = 40'(pos_y_reg) + 40'(v1y_reg) + 40'(v2y_reg); end
            2'd1: begin ex_x = 40'(pos_x_reg) + 40'(v1x_reg) - 40'(v2x_reg);
                        ex_y = 40'(pos_y_reg) + 40'(v1y_reg) - 40'(v2y_reg); end
            2'd2: begin ex_x = 40'(pos_x_reg) - 40'(v1x_reg) - 40'(v2x_reg);
                        ex_y = 40'(pos_y_reg) - 40'(v1y_reg) - 40'(v2y_reg); end
            default: begin ex_x = 40'(pos_x_reg) - 40'(v1x_reg) + 40'(v2x_reg);
                        ex_y = 40'(pos_y_reg) - 40'(v1y_reg) + 40'(v2y_reg); end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            pend_reg    <= 1'b0;
            iter_reg    <= '0;
        end else begin
            if (cmd.load_in) begin
                lin_reg <= lin_speed;
                rot_reg <= rot_speed;
            end
            if (cmd.cordic_init) begin
                iter_reg <= '0;
                cy_reg   <= '0;
                cx_reg   <= ddpi_pkg::CORDIC_START;
                if (z0 > ddpi_pkg::HALF_PI_Q30) begin
                    cz_reg <= z0 - ddpi_pkg::PI_Q30; neg_reg <= 1'b1;
                end else if (z0 < -ddpi_pkg::HALF_PI_Q30) begin
                    cz_reg <= z0 + ddpi_pkg::PI_Q30; neg_reg <= 1'b1;
                end else begin
                    cz_reg <= z0; neg_reg <= 1'b0;
                end
            end else if (cmd.cordic_step) begin
                iter_reg <= iter_reg + 1'b1;
                if (!cz_reg[35]) begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - ddpi_pkg::atan_q30(iter_reg);
                end else begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + ddpi_pkg::atan_q30(iter_reg);
                end
            end
            if (cmd.cordic_done) begin
                cos_reg <= 25'((rx + 36'sd128) >>> 8);
                sin_reg <= 25'((ry + 36'sd128) >>> 8);
            end
            pend_reg <= cmd.mul_en;
            psel_reg <= cmd.mul_sel;
            if (cmd.mul_en)
                prod_reg <= 66'(ma) * 66'(mb);
            if (pend_reg) begin
                case (psel_reg)
                    ddpi_pkg::MUL_DIST: dist_reg <= prod_reg[40:0];
                    ddpi_pkg::MUL_DCOS_HI:
                        pos_x_reg <= ddpi_pkg::sat32(40'(pos_x_reg) + 40'(rnd38));
                    ddpi_pkg::MUL_DSIN_HI:
                        pos_y_reg <= ddpi_pkg::sat32(40'(pos_y_reg) + 40'(rnd38));
                    ddpi_pkg::MUL_ROT: begin
                        if (h_sum > 40'(ddpi_pkg::PI_H))
                            heading_reg <= 16'(h_sum - 40'(ddpi_pkg::TWO_PI_H));
                        else if (h_sum <= -40'(ddpi_pkg::PI_H))
                            heading_reg <= 16'(h_sum + 40'(ddpi_pkg::TWO_PI_H));
                        else
                            heading_reg <= h_sum[15:0];
                    end
                    ddpi_pkg::MUL_DCOS, ddpi_pkg::MUL_DSIN,
                    ddpi_pkg::MUL_CFX, ddpi_pkg::MUL_SFX,
                    ddpi_pkg::MUL_CSX, ddpi_pkg::MUL_SSX: acc_reg <= prod_reg;
                    default: ;
                endcase
                case (psel_reg)
                    ddpi_pkg::MUL_SFY: v1x_reg <= 37'((acc_reg - prod_reg + (66'sd1 <<< 21)) >>> 22);
                    ddpi_pkg::MUL_CFY: v1y_reg <= 37'(rnd22v);
                    ddpi_pkg::MUL_SSY: v2x_reg <= 37'((acc_reg - prod_reg + (66'sd1 <<< 21)) >>> 22);
                    ddpi_pkg::MUL_CSY: v2y_reg <= 37'(rnd22v);
                    default: ;
                endcase
            end
            if (cmd.load_corner) begin
                corner_x_reg <= ddpi_pkg::sat32(ex_x);
                corner_y_reg <= ddpi_pkg::sat32(ex_y);
            end
        end
    end

    assign corner_x     = corner_x_reg;
    assign corner_y     = corner_y_reg;
    assign pose_x       = pos_x_reg;
    assign pose_y       = pos_y_reg;
    assign pose_heading = heading_reg;

    // heading stays in (-pi, pi]
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (heading_reg <= ddpi_pkg::PI_H) && (heading_reg > -ddpi_pkg::PI_H))
        else $error("heading out of range");
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cordic_step |-> (iter_reg < ddpi_pkg::IterW'(ddpi_pkg::CORDIC_ITERATIONS)))
        else $error("cordic overrun");
    a_pose_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(pend_reg) |-> $stable(heading_reg))
        else $error("heading changed without product");

endmodule

FILE: rtl/ddpi_ctrl.sv
// ddpi_ctrl: sequencer for the pose integrator datapath.
// Depends on ddpi_pkg; drives ddpi_dp through dp_cmd_t.
module ddpi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_fire,
    input  ddpi_pkg::dp_stat_t  stat,
    output ddpi_pkg::dp_cmd_t   cmd,
    output logic                in_ready,
    output logic                out_valid,
    output logic [1:0]          corner_index,
    output logic                last
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CINI1 = 9'b000000010,
        S_CRD1  = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_CINI2 = 9'b000010000,
        S_CRD2  = 9'b000100000,
        S_MUL2  = 9'b001000000,
        S_CORN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] corner_reg, corner_next;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        cmd         = '0;
        cmd.mul_sel = ddpi_pkg::MUL_DIST;
        cmd.corner  = corner_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CINI1;
                end
            end
            S_CINI1: begin
                cmd.cordic_init = 1'b1;
                state_next = S_CRD1;
            end
            S_CRD1: begin
                cmd.cordic_step = 1'b1;
                if (stat.last_iter) begin
                    state_next = S_MUL1;
                    step_next  = '0;
                end
            end
            S_MUL1: begin
                // first step rounds CORDIC; then dist, an idle slot, dcos lo/hi, dsin lo/hi, rot, drain
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0: cmd.cordic_done = 1'b1;
                    4'd1: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_DIST; end
                    4'd2: begin cmd.mul_en = 1'b0; end
                    4'd3: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_DCOS; end
                    4'd4: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_DCOS_HI; end
                    4'd5: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_DSIN; end
                    4'd6: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_DSIN_HI; end
                    4'd7: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_ROT; end
                    default: begin
                        state_next = S_CINI2;
                    end
                endcase
            end
            S_CINI2: begin
                cmd.cordic_init = 1'b1;
                state_next = S_CRD2;
            end
            S_CRD2: begin
                cmd.cordic_step = 1'b1;
                if (stat.last_iter) begin
                    state_next = S_MUL2;
                    step_next  = '0;
                end
            end
            S_MUL2: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0: cmd.cordic_done = 1'b1;
                    4'd1: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_CFX; end
                    4'd2: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_SFY; end
                    4'd3: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_SFX; end
                    4'd4: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_CFY; end
                    4'd5: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_CSX; end
                    4'd6: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_SSY; end
                    4'd7: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_SSX; end
                    4'd8: begin cmd.mul_en = 1'b1; cmd.mul_sel = ddpi_pkg::MUL_CSY; end
                    4'd9: ;
                    default: begin
                        state_next  = S_CORN;
                        corner_next = '0;
                    end
                endcase
            end
            S_CORN: begin
                cmd.load_corner = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_fire) begin
                    corner_next = corner_reg + 1'b1;
                    state_next  = (corner_reg == 2'd3) ? S_IDLE : S_CORN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            corner_reg <= '0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign corner_index = corner_reg;
    assign last         = (corner_reg == 2'd3);

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid)) else $error("input and output both open");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && last) |=> (state_reg == S_IDLE)) else $error("no return to idle");
    a_corner_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !last) |=> (corner_reg == $past(corner_reg) + 2'd1))
        else $error("corner skipped");

endmodule

FILE: rtl/diff_drive_pose_integrator.sv
// diff_drive_pose_integrator: top level, config registers and stream ports.
// Depends on ddpi_pkg, ddpi_ctrl and ddpi_dp.
//
// Usage:
//   s_axis: one velocity command per transaction, tdata = {rot_speed, lin_speed}.
//   m_axis: four corner transactions per command, corner 0..3 (++, +-, --, -+),
//     tlast set on corner 3; each also carries the new pose.
//   cfg_*: write-only port; the user writes it only while idle, not enforced.
// Sequence: from command acceptance to the first corner offered, two
//   CORDIC passes of 16 iterations each with a start state, 14
//   shared-multiplier slots with rounding and drain steps, one corner load.
//   Each further corner is loaded after the previous one is taken.
// Rate: bounded by the single shared 33x33 multiplier and the serial
//   CORDIC, plus output stall time.
// Reset: pose and heading clear to zero, registers take their reset values,
//   s_axis_tready is high from the first cycle after reset.
// Stall: a corner is held in output registers while m_axis_tready is low;
//   no new command is taken until all four corners are delivered.
module diff_drive_pose_integrator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // lin_speed[23:0], rot_speed[47:24]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // corner_index[1:0], corner_x[33:2],
                                         // corner_y[65:34], pose_x[97:66],
                                         // pose_y[129:98], pose_heading[145:130]
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic [15:0]        time_step_reg;
    logic signed [31:0] front_x_reg, front_y_reg, side_x_reg, side_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= 16'd6554;
            front_x_reg   <= 32'sd16384;
            front_y_reg   <= '0;
            side_x_reg    <= '0;
            side_y_reg    <= 32'sd16384;
        end else if (cfg_we) begin
            case (cfg_index)
                ddpi_pkg::REG_TIME_STEP: time_step_reg <= cfg_wdata[15:0];
                ddpi_pkg::REG_FRONT_X:   front_x_reg   <= cfg_wdata;
                ddpi_pkg::REG_FRONT_Y:   front_y_reg   <= cfg_wdata;
                ddpi_pkg::REG_SIDE_X:    side_x_reg    <= cfg_wdata;
                ddpi_pkg::REG_SIDE_Y:    side_y_reg    <= cfg_wdata;
                default: ; // writes beyond the list are dropped
            endcase
        end
    end

    ddpi_pkg::dp_cmd_t  cmd;
    ddpi_pkg::dp_stat_t stat;
    logic               in_fire, out_fire;
    logic [1:0]         corner_index;
    logic signed [31:0] corner_x, corner_y, pose_x, pose_y;
    logic signed [15:0] pose_heading;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ddpi_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .out_fire     (out_fire),
        .stat         (stat),
        .cmd          (cmd),
        .in_ready     (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .corner_index (corner_index),
        .last         (m_axis_tlast)
    );

    ddpi_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .lin_speed    (s_axis_tdata[23:0]),
        .rot_speed    (s_axis_tdata[47:24]),
        .time_step    (time_step_reg),
        .front_x      (front_x_reg),
        .front_y      (front_y_reg),
        .side_x       (side_x_reg),
        .side_y       (side_y_reg),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading)
    );

    assign m_axis_tdata = {6'd0, pose_heading, pose_y, pose_x, corner_y, corner_x,
                           corner_index};

endmodule
